/* rtl/core/tbah_pkg.sv */
// tbah_pkg: shared types and constants of the tiered bucket average history
// depends on nothing; used by the divider, the ring and the top level
package tbah_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_QUERY  = 2'd1,
    OP_LATEST = 2'd2,
    OP_COUNT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_FINE_IV   = 2'd0,
    REG_COARSE_IV = 2'd1,
    REG_FINE_WIN  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  localparam int unsigned DivW = 33;  // sum plus half count
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [6:0]  MaxOut   = 7'd64;

  // ring entry: bucket end time and rounded averages
  typedef struct packed {
    logic [31:0] time_s;
    logic [15:0] solar;
    logic [15:0] battery;
    logic [15:0] speed;
  } entry_t;

  // one result transaction without the last flag
  typedef struct packed {
    logic [31:0] time_s;
    logic [15:0] speed;
    logic [15:0] battery;
    logic [15:0] solar;
    logic        found;
    logic [11:0] total;
  } res_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [15:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [15:0]     remainder;
  } div_rsp_t;

endpackage

/* rtl/core/tbah_if.sv */
// tbah_in_if / tbah_out_if: valid-ready channels of the input and result transactions
// no dependencies
interface tbah_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] sample_time;
  logic [15:0] speed_deci;
  logic [15:0] battery_centi;
  logic [15:0] solar_centi;
  logic [31:0] window_seconds;
  logic [6:0]  max_out;
  modport source (output valid, op, sample_time, speed_deci, battery_centi, solar_centi,
                  window_seconds, max_out, input ready);
  modport sink (input valid, op, sample_time, speed_deci, battery_centi, solar_centi,
                window_seconds, max_out, output ready);
endinterface

interface tbah_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_time;
  logic [15:0] out_speed;
  logic [15:0] out_battery;
  logic [15:0] out_solar;
  logic        found;
  logic [11:0] total_count;
  logic        last;
  modport source (output valid, out_time, out_speed, out_battery, out_solar, found,
                  total_count, last, input ready);
  modport sink (input valid, out_time, out_speed, out_battery, out_solar, found,
                total_count, last, output ready);
endinterface

/* rtl/core/tbah_div.sv */
// tbah_div: restoring divider, one quotient bit per cycle
// depends on tbah_pkg
module tbah_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tbah_pkg::div_req_t req,
  output tbah_pkg::div_rsp_t rsp
);
  localparam int unsigned CW = $clog2(tbah_pkg::DivW + 1);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [tbah_pkg::DivW-1:0] quo_r, quo_nxt;
  logic [15:0]               rem_r, rem_nxt;
  logic [15:0]               dvs_r, dvs_nxt;
  logic [16:0]               trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[tbah_pkg::DivW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(tbah_pkg::DivW);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[tbah_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[tbah_pkg::DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;
endmodule

/* rtl/core/tbah_ring.sv */
// tbah_ring: entry store of one tier, one write and one registered read port
// depends on tbah_pkg
module tbah_ring #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  tbah_pkg::entry_t         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output tbah_pkg::entry_t         rdata
);
  tbah_pkg::entry_t mem [DEPTH];
  tbah_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/core/tiered_bucket_average_history.sv */
// tiered_bucket_average_history: top level, sequencer around one shared divider
// depends on tbah_pkg, tbah_if, tbah_div, tbah_ring
//
// channel | dir | transaction
// in_ch   | in  | op, sample_time, speed/battery/solar, window_seconds, max_out
// out_ch  | out | out_time, out_speed/battery/solar, found, total_count, last
// cfg_*   | in  | write enable, register index, 24 bit data, no read-back
//
// one transaction at a time; in_ch.ready is high only in the idle state
// a push divides for each tier's bucket start, and also averages when a tier closes a bucket
// (each divide steps through start, 33 quotient bits, done; one divide for
// each bucket start and for each of three averages)
// a window query reads each walked ring entry in turn, then divides for the
// pending bucket averages, and each result waits on out_ch.ready
// synchronous reset clears control state; the rings need no clearing pass
module tiered_bucket_average_history #(
  parameter int unsigned FINE_DEPTH   = 512,
  parameter int unsigned COARSE_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  tbah_in_if.sink     in_ch,
  tbah_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  localparam int unsigned FAW = $clog2(FINE_DEPTH);
  localparam int unsigned FNW = $clog2(FINE_DEPTH + 1);
  localparam int unsigned CAW = $clog2(COARSE_DEPTH);
  localparam int unsigned CNW = $clog2(COARSE_DEPTH + 1);
  localparam int unsigned IW  = (FAW > CAW) ? FAW : CAW;
  localparam int unsigned NW  = IW + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_BDIV  = 12'b0000_0000_0010,
    S_BWAIT = 12'b0000_0000_0100,
    S_ADIV  = 12'b0000_0000_1000,
    S_AWAIT = 12'b0000_0001_0000,
    S_RPUSH = 12'b0000_0010_0000,
    S_BOPEN = 12'b0000_0100_0000,
    S_QRD   = 12'b0000_1000_0000,
    S_QCHK  = 12'b0001_0000_0000,
    S_QPEND = 12'b0010_0000_0000,
    S_FIN   = 12'b0100_0000_0000,
    S_OWAIT = 12'b1000_0000_0000
  } state_t;

  // sequencer
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   tier_r, tier_nxt;           // 0 fine, 1 coarse
  logic   push_r, push_nxt;           // averaging for a push, else for a query
  logic [1:0] k_r, k_nxt;             // field being averaged
  logic [15:0] avg_r [3];
  logic [15:0] avg_nxt [3];

  // latched input transaction
  logic [31:0] ts_r, ts_nxt;
  logic [15:0] spd_r, spd_nxt, bat_r, bat_nxt, sol_r, sol_nxt;
  logic [6:0]  maxo_r, maxo_nxt, nout_r, nout_nxt;
  logic [31:0] cutoff_r, cutoff_nxt, snew_r, snew_nxt;
  logic [IW-1:0] qidx_r, qidx_nxt;
  logic [NW-1:0] qcnt_r, qcnt_nxt;

  // configuration
  logic [15:0] fiv_r, fiv_nxt, civ_r, civ_nxt;
  logic [23:0] fwin_r, fwin_nxt;

  // history state
  logic        lvalid_r, lvalid_nxt;
  logic [31:0] ltime_r, ltime_nxt;
  logic [15:0] lspd_r, lspd_nxt, lbat_r, lbat_nxt, lsol_r, lsol_nxt;
  logic [FAW-1:0] fhead_r, fhead_nxt;
  logic [FNW-1:0] ffill_r, ffill_nxt;
  logic [CAW-1:0] chead_r, chead_nxt;
  logic [CNW-1:0] cfill_r, cfill_nxt;
  logic        bact_r [2];
  logic        bact_nxt [2];
  logic [31:0] bstart_r [2];
  logic [31:0] bstart_nxt [2];
  logic [31:0] bsum_r [6];
  logic [31:0] bsum_nxt [6];
  logic [15:0] bcnt_r [2];
  logic [15:0] bcnt_nxt [2];

  // result staging: one held result so the final one can carry last
  tbah_pkg::res_t hold_r, hold_nxt, out_r, out_nxt, new_res;
  logic hold_v_r, hold_v_nxt, olast_r, olast_nxt, ovalid_r, ovalid_nxt;

  // shared divider and rings
  tbah_pkg::div_req_t div_req;
  tbah_pkg::div_rsp_t div_rsp;
  logic             fwe, cwe;
  tbah_pkg::entry_t wentry, frd, crd, rd;

  // per-tier views
  logic [15:0]   iv_sel;
  logic [31:0]   pend_end;
  logic          pend_has;
  logic [NW-1:0] fill_sel, depth_sel;
  logic [2:0]    sidx;
  logic          in_acc;
  logic [6:0]    maxo_in;
  logic          tier_in;
  logic [NW-1:0] head_q, fill_q, depth_q, base_q;
  logic [31:0]   total;

  tbah_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  tbah_ring #(.DEPTH(FINE_DEPTH)) u_fine (
    .clk  (clk),
    .we   (fwe),
    .waddr(fhead_r),
    .wdata(wentry),
    .raddr(qidx_r[FAW-1:0]),
    .rdata(frd)
  );

  tbah_ring #(.DEPTH(COARSE_DEPTH)) u_coarse (
    .clk  (clk),
    .we   (cwe),
    .waddr(chead_r),
    .wdata(wentry),
    .raddr(qidx_r[CAW-1:0]),
    .rdata(crd)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // interval register of zero acts as one
  always_comb begin
    iv_sel = tier_r ? civ_r : fiv_r;
    if (iv_sel == 16'd0) begin
      iv_sel = 16'd1;
    end
  end

  assign pend_end  = bstart_r[tier_r] + {16'd0, iv_sel};
  assign pend_has  = bact_r[tier_r] && (bcnt_r[tier_r] != 16'd0);
  assign fill_sel  = tier_r ? NW'(cfill_r) : NW'(ffill_r);
  assign depth_sel = tier_r ? NW'(COARSE_DEPTH) : NW'(FINE_DEPTH);
  assign sidx      = 3'(k_r) + (tier_r ? 3'd3 : 3'd0);
  assign rd        = tier_r ? crd : frd;

  // query setup from the incoming transaction: tier and oldest ring entry
  assign maxo_in = (in_ch.max_out > tbah_pkg::MaxOut) ? tbah_pkg::MaxOut : in_ch.max_out;
  assign tier_in = !(in_ch.window_seconds <= {8'd0, fwin_r});
  assign head_q  = tier_in ? NW'(chead_r) : NW'(fhead_r);
  assign fill_q  = tier_in ? NW'(cfill_r) : NW'(ffill_r);
  assign depth_q = tier_in ? NW'(COARSE_DEPTH) : NW'(FINE_DEPTH);
  assign base_q  = (head_q >= fill_q) ? (head_q - fill_q) : (head_q + depth_q - fill_q);
  assign total   = 32'(ffill_r) + 32'(cfill_r)
                 + ((bact_r[0] && bcnt_r[0] != 16'd0) ? 32'd1 : 32'd0)
                 + ((bact_r[1] && bcnt_r[1] != 16'd0) ? 32'd1 : 32'd0);

  assign wentry.time_s  = pend_end;
  assign wentry.speed   = avg_r[0];
  assign wentry.battery = avg_r[1];
  assign wentry.solar   = avg_r[2];

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    tier_nxt  = tier_r;
    push_nxt  = push_r;
    k_nxt     = k_r;
    avg_nxt   = avg_r;
    ts_nxt    = ts_r;
    spd_nxt   = spd_r;
    bat_nxt   = bat_r;
    sol_nxt   = sol_r;
    maxo_nxt  = maxo_r;
    nout_nxt  = nout_r;
    cutoff_nxt = cutoff_r;
    snew_nxt  = snew_r;
    qidx_nxt  = qidx_r;
    qcnt_nxt  = qcnt_r;
    fiv_nxt   = fiv_r;
    civ_nxt   = civ_r;
    fwin_nxt  = fwin_r;
    lvalid_nxt = lvalid_r;
    ltime_nxt = ltime_r;
    lspd_nxt  = lspd_r;
    lbat_nxt  = lbat_r;
    lsol_nxt  = lsol_r;
    fhead_nxt = fhead_r;
    ffill_nxt = ffill_r;
    chead_nxt = chead_r;
    cfill_nxt = cfill_r;
    bact_nxt  = bact_r;
    bstart_nxt = bstart_r;
    bsum_nxt  = bsum_r;
    bcnt_nxt  = bcnt_r;
    hold_nxt  = hold_r;
    hold_v_nxt = hold_v_r;
    out_nxt   = out_r;
    olast_nxt = olast_r;
    ovalid_nxt = ovalid_r;
    fwe = 1'b0;
    cwe = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, ts_r};
    div_req.divisor  = iv_sel;
    new_res = '0;

    if (cfg_we) begin
      case (tbah_pkg::reg_idx_t'(cfg_index))
        tbah_pkg::REG_FINE_IV:   fiv_nxt  = cfg_wdata[15:0];
        tbah_pkg::REG_COARSE_IV: civ_nxt  = cfg_wdata[15:0];
        tbah_pkg::REG_FINE_WIN:  fwin_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hold_v_nxt = 1'b0;
          hold_nxt   = '0;
          case (tbah_pkg::op_t'(in_ch.op))
            tbah_pkg::OP_PUSH: begin
              lvalid_nxt = 1'b1;
              ltime_nxt  = in_ch.sample_time;
              lspd_nxt   = in_ch.speed_deci;
              lbat_nxt   = in_ch.battery_centi;
              lsol_nxt   = in_ch.solar_centi;
              ts_nxt     = in_ch.sample_time;
              spd_nxt    = in_ch.speed_deci;
              bat_nxt    = in_ch.battery_centi;
              sol_nxt    = in_ch.solar_centi;
              tier_nxt   = 1'b0;
              push_nxt   = 1'b1;
              state_nxt  = S_BDIV;
            end
            tbah_pkg::OP_QUERY: begin
              push_nxt   = 1'b0;
              tier_nxt   = tier_in;
              maxo_nxt   = maxo_in;
              nout_nxt   = '0;
              qcnt_nxt   = '0;
              qidx_nxt   = base_q[IW-1:0];
              cutoff_nxt = (ltime_r > in_ch.window_seconds) ?
                           (ltime_r - in_ch.window_seconds) : 32'd0;
              if (!lvalid_r || maxo_in == 7'd0 || in_ch.window_seconds == 32'd0) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_QRD;
              end
            end
            tbah_pkg::OP_LATEST: begin
              hold_v_nxt       = lvalid_r;
              hold_nxt.time_s  = ltime_r;
              hold_nxt.speed   = lspd_r;
              hold_nxt.battery = lbat_r;
              hold_nxt.solar   = lsol_r;
              hold_nxt.found   = 1'b1;
              state_nxt        = S_FIN;
            end
            default: begin
              hold_v_nxt     = 1'b1;
              hold_nxt.total = total[11:0];
              state_nxt      = S_FIN;
            end
          endcase
        end
      end

      // bucket start: timestamp minus its remainder by the interval
      S_BDIV: begin
        div_req.start = 1'b1;
        state_nxt     = S_BWAIT;
      end

      S_BWAIT: begin
        if (div_rsp.done) begin
          snew_nxt = ts_r - {16'd0, div_rsp.remainder};
          if (!bact_r[tier_r] || (ts_r - {16'd0, div_rsp.remainder}) != bstart_r[tier_r]) begin
            k_nxt     = '0;
            state_nxt = pend_has ? S_ADIV : S_BOPEN;
          end else begin
            // same bucket: accumulate unless the count is full
            if (bcnt_r[tier_r] != tbah_pkg::CountMax) begin
              bsum_nxt[3'(tier_r) * 3'd3]        = bsum_r[3'(tier_r) * 3'd3] + {16'd0, spd_r};
              bsum_nxt[3'(tier_r) * 3'd3 + 3'd1] = bsum_r[3'(tier_r) * 3'd3 + 3'd1]
                                                   + {16'd0, bat_r};
              bsum_nxt[3'(tier_r) * 3'd3 + 3'd2] = bsum_r[3'(tier_r) * 3'd3 + 3'd2]
                                                   + {16'd0, sol_r};
              bcnt_nxt[tier_r] = bcnt_r[tier_r] + 16'd1;
            end
            if (!tier_r) begin
              tier_nxt  = 1'b1;
              state_nxt = S_BDIV;
            end else begin
              state_nxt = S_IDLE;
            end
          end
        end
      end

      // rounded average: (sum + count/2) / count
      S_ADIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, bsum_r[sidx]} + {17'd0, 1'b0, bcnt_r[tier_r][15:1]};
        div_req.divisor  = bcnt_r[tier_r];
        state_nxt        = S_AWAIT;
      end

      S_AWAIT: begin
        if (div_rsp.done) begin
          avg_nxt[k_r] = div_rsp.quotient[15:0];
          if (k_r == 2'd2) begin
            state_nxt = push_r ? S_RPUSH : S_QPEND;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_ADIV;
          end
        end
      end

      S_RPUSH: begin
        if (!tier_r) begin
          fwe       = 1'b1;
          fhead_nxt = (fhead_r == FAW'(FINE_DEPTH - 1)) ? '0 : fhead_r + 1'b1;
          if (ffill_r != FNW'(FINE_DEPTH)) ffill_nxt = ffill_r + 1'b1;
        end else begin
          cwe       = 1'b1;
          chead_nxt = (chead_r == CAW'(COARSE_DEPTH - 1)) ? '0 : chead_r + 1'b1;
          if (cfill_r != CNW'(COARSE_DEPTH)) cfill_nxt = cfill_r + 1'b1;
        end
        state_nxt = S_BOPEN;
      end

      S_BOPEN: begin
        bact_nxt[tier_r]                   = 1'b1;
        bstart_nxt[tier_r]                 = snew_r;
        bsum_nxt[3'(tier_r) * 3'd3]        = {16'd0, spd_r};
        bsum_nxt[3'(tier_r) * 3'd3 + 3'd1] = {16'd0, bat_r};
        bsum_nxt[3'(tier_r) * 3'd3 + 3'd2] = {16'd0, sol_r};
        bcnt_nxt[tier_r]                   = 16'd1;
        if (!tier_r) begin
          tier_nxt  = 1'b1;
          state_nxt = S_BDIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // ring walk, oldest first; read address is qidx_r
      S_QRD: begin
        if (qcnt_r < fill_sel && nout_r < maxo_r) begin
          state_nxt = S_QCHK;
        end else if (nout_r < maxo_r && pend_has && pend_end >= cutoff_r) begin
          k_nxt     = '0;
          state_nxt = S_ADIV;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_QCHK: begin
        qcnt_nxt  = qcnt_r + 1'b1;
        qidx_nxt  = (NW'(qidx_r) == depth_sel - 1'b1) ? '0 : qidx_r + 1'b1;
        state_nxt = S_QRD;
        if (rd.time_s >= cutoff_r) begin
          new_res.time_s  = rd.time_s;
          new_res.speed   = rd.speed;
          new_res.battery = rd.battery;
          new_res.solar   = rd.solar;
          new_res.found   = 1'b1;
          nout_nxt        = nout_r + 7'd1;
          hold_nxt        = new_res;
          hold_v_nxt      = 1'b1;
          if (hold_v_r) begin
            out_nxt    = hold_r;
            olast_nxt  = 1'b0;
            ovalid_nxt = 1'b1;
            ret_nxt    = S_QRD;
            state_nxt  = S_OWAIT;
          end
        end
      end

      S_QPEND: begin
        new_res.time_s  = pend_end;
        new_res.speed   = avg_r[0];
        new_res.battery = avg_r[1];
        new_res.solar   = avg_r[2];
        new_res.found   = 1'b1;
        nout_nxt        = nout_r + 7'd1;
        hold_nxt        = new_res;
        hold_v_nxt      = 1'b1;
        state_nxt       = S_FIN;
        if (hold_v_r) begin
          out_nxt    = hold_r;
          olast_nxt  = 1'b0;
          ovalid_nxt = 1'b1;
          ret_nxt    = S_FIN;
          state_nxt  = S_OWAIT;
        end
      end

      // final result, or the empty marker when nothing is held
      S_FIN: begin
        out_nxt    = hold_v_r ? hold_r : '0;
        olast_nxt  = 1'b1;
        ovalid_nxt = 1'b1;
        ret_nxt    = S_IDLE;
        state_nxt  = S_OWAIT;
      end

      S_OWAIT: begin
        if (out_ch.ready) begin
          ovalid_nxt = 1'b0;
          state_nxt  = ret_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      ovalid_r <= 1'b0;
      hold_v_r <= 1'b0;
      fiv_r    <= 16'd5;
      civ_r    <= 16'd300;
      fwin_r   <= 24'd1800;
      lvalid_r <= 1'b0;
      ltime_r  <= '0;
      lspd_r   <= '0;
      lbat_r   <= '0;
      lsol_r   <= '0;
      fhead_r  <= '0;
      ffill_r  <= '0;
      chead_r  <= '0;
      cfill_r  <= '0;
      bact_r   <= '{default: 1'b0};
      bstart_r <= '{default: '0};
      bsum_r   <= '{default: '0};
      bcnt_r   <= '{default: '0};
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      ovalid_r <= ovalid_nxt;
      hold_v_r <= hold_v_nxt;
      fiv_r    <= fiv_nxt;
      civ_r    <= civ_nxt;
      fwin_r   <= fwin_nxt;
      lvalid_r <= lvalid_nxt;
      ltime_r  <= ltime_nxt;
      lspd_r   <= lspd_nxt;
      lbat_r   <= lbat_nxt;
      lsol_r   <= lsol_nxt;
      fhead_r  <= fhead_nxt;
      ffill_r  <= ffill_nxt;
      chead_r  <= chead_nxt;
      cfill_r  <= cfill_nxt;
      bact_r   <= bact_nxt;
      bstart_r <= bstart_nxt;
      bsum_r   <= bsum_nxt;
      bcnt_r   <= bcnt_nxt;
    end
    tier_r   <= tier_nxt;
    push_r   <= push_nxt;
    k_r      <= k_nxt;
    avg_r    <= avg_nxt;
    ts_r     <= ts_nxt;
    spd_r    <= spd_nxt;
    bat_r    <= bat_nxt;
    sol_r    <= sol_nxt;
    maxo_r   <= maxo_nxt;
    nout_r   <= nout_nxt;
    cutoff_r <= cutoff_nxt;
    snew_r   <= snew_nxt;
    qidx_r   <= qidx_nxt;
    qcnt_r   <= qcnt_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.out_time    = out_r.time_s;
  assign out_ch.out_speed   = out_r.speed;
  assign out_ch.out_battery = out_r.battery;
  assign out_ch.out_solar   = out_r.solar;
  assign out_ch.found       = out_r.found;
  assign out_ch.total_count = out_r.total;
  assign out_ch.last        = olast_r;
endmodule

/* rtl/core/tbah_checker.sv */
// tbah_checker: port-level assertions of the tiered bucket average history
// depends on tiered_bucket_average_history (bound below)
module tbah_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_time,
  input logic [15:0] out_speed,
  input logic        found
);
  // result transaction held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_time))
    else $error("result dropped or changed while stalled");

  // no new input while a result is waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an accepted transaction");

  // empty marker and count results carry zero sample fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> out_time == 32'd0 && out_speed == 16'd0)
    else $error("sample fields set on a result without a sample");
endmodule

bind tiered_bucket_average_history tbah_checker u_tbah_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_time (out_ch.out_time),
  .out_speed(out_ch.out_speed),
  .found    (out_ch.found)
);
